// ===== hdl/throttle_current_band_slew_limiter_defines.svh =====
// Assertion macros shared by the throttle slew limiter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef THROTTLE_CURRENT_BAND_SLEW_LIMITER_DEFINES_SVH
`define THROTTLE_CURRENT_BAND_SLEW_LIMITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/tcbsl_pkg.sv =====
// Package for the throttle slew limiter: widths, reset values, codes and types.
// No dependencies; imported by tcbsl_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcbsl_pkg;

    // fixed point
    localparam int Q_FRAC           = 14;
    localparam int Q_ONE            = 16384;
    localparam int STANDSTILL_SPEED = 688;
    localparam int ROLLING_SPEED    = 655;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 12;
    localparam int DELTA_W    = 13;
    localparam int CMD_W      = 16;
    localparam int PULSE_W    = 16;
    localparam int QREG_W     = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int COUNT_MODULUS     = 4096;
    localparam int PERIOD_COUNTS_DEF = 37500;

    // pulse width = round((3*Q_ONE - cmd) * period / (20*Q_ONE))
    localparam int PULSE_OFFSET = 3 * Q_ONE;
    localparam int PULSE_DEN    = 20 * Q_ONE;

    // shared divider: quotient below 2**DIV_Q_W by construction
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 19;
    localparam int DIV_Q_W   = 15;

    // register reset values
    localparam logic [11:0] THROTTLE_LOW_RST       = 12'd700;
    localparam logic [11:0] THROTTLE_HIGH_RST      = 12'd2000;
    localparam logic [11:0] FULL_SPEED_DIV_RST     = 12'd836;
    localparam logic [14:0] BAND_FULL_RST          = 15'd2294;
    localparam logic [14:0] BAND_STOPPED_RST       = 15'd4424;
    localparam logic [14:0] BAND_STANDSTILL_RST    = 15'd6554;
    localparam logic [14:0] ROLLING_MIN_RST        = 15'd1638;
    localparam logic [14:0] SLEW_STEP_RST          = 15'd109;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_LOW       = 3'd0,
        CFG_THROTTLE_HIGH      = 3'd1,
        CFG_FULL_SPEED_DIVISOR = 3'd2,
        CFG_BAND_FULL          = 3'd3,
        CFG_BAND_STOPPED       = 3'd4,
        CFG_BAND_STANDSTILL    = 3'd5,
        CFG_ROLLING_MIN        = 3'd6,
        CFG_SLEW_STEP          = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_PEDAL_WAIT,
        S_SPEED,
        S_SPEED_WAIT,
        S_BAND_MUL,
        S_BAND,
        S_CLAMP,
        S_FLOOR,
        S_SLEW,
        S_PULSE_MUL,
        S_PULSE_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hdl/tcbsl_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on tcbsl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "throttle_current_band_slew_limiter_defines.svh"

module tcbsl_div
    import tcbsl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_Q_W-1:0]   r_quot;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    // bring down the next numerator bit and try a subtract
    assign w_trial = {r_rem, r_low[DIV_Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // the numerator is below den * 2**DIV_Q_W, so its top part is below den
            r_rem <= DIV_DEN_W'(i_req.num[DIV_NUM_W-1:DIV_Q_W]);
            r_low <= i_req.num[DIV_Q_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            r_low  <= {r_low[DIV_Q_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    `ASSERT_NEVER(a_no_restart, i_clk, i_rst_n, i_req.start && r_busy)
    `ASSERT_IMPLY(a_done_after_busy, i_clk, i_rst_n, r_done, !r_busy && $past(r_busy))
    `ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, r_busy, r_rem < r_den)

endmodule

`default_nettype wire

// ===== hdl/throttle_current_band_slew_limiter.sv =====
// Throttle limiter: each word carries a pedal ADC sample and an encoder count, and
// returns a servo compare value, the wrapped count delta and the slew-limited command.
// The pedal is scaled between throttle_low and throttle_high into Q1.14 and clamped
// to 0..1; the count delta over full_speed_divisor gives a speed clamped to -1..+1.
// The command is held in a band around the speed whose half-width falls linearly
// with |speed| (a fixed wide band below standstill), gets a floor while rolling
// forward, and moves at most slew_step per word. The first word after reset reports
// a delta of 0. A small sequencer drives one shared restoring divider (used for
// the pedal and the speed) and one multiplier; the pulse width divides by a
// constant through a shift and a reciprocal multiply. A word skips the pedal
// division when the pedal sample lies at or outside the throttle limits and the
// speed division when the speed saturates, and it waits before returning to idle
// while the previous result still waits in the output register.
// The input is not ready while a word is in progress; a finished result sits in
// the output register while the next word is accepted.
// Write configuration only while the block is idle.
// Depends on tcbsl_pkg, tcbsl_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "throttle_current_band_slew_limiter_defines.svh"

module throttle_current_band_slew_limiter
    import tcbsl_pkg::*;
#(
    parameter int unsigned PERIOD_COUNTS = PERIOD_COUNTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input words
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [SAMPLE_W-1:0]          i_throttle_sample,
    input  wire logic [COUNT_W-1:0]           i_encoder_count,
    // result words
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [PULSE_W-1:0]                o_pulse_compare,
    output logic signed [DELTA_W-1:0]         o_count_delta,
    output logic signed [CMD_W-1:0]           o_drive_command
);

    // wide signed width for the band and slew compares
    localparam int CW = 19;
    localparam logic signed [CW-1:0] CMD_HI = CW'((1 << (CMD_W - 1)) - 1);
    localparam logic signed [CW-1:0] CMD_LO = -CMD_HI - CW'(1);
    localparam logic [PULSE_W-1:0]   PERIOD_V = PULSE_W'(PERIOD_COUNTS);
    localparam logic signed [PULSE_W:0] PERIOD_MAX = (PULSE_W + 1)'(PERIOD_COUNTS - 1);
    localparam logic signed [13:0]   HALF_MOD = 14'(COUNT_MODULUS / 2);
    localparam logic signed [13:0]   FULL_MOD = 14'(COUNT_MODULUS);

    // pulse denominator is 5 * 2**PULSE_DEN_SH; the divide by 5 uses
    // ceil(2**DIV5_SH / 5), exact for dividends below 2**DIV5_SH
    localparam int          PULSE_DEN_SH = Q_FRAC + 2;
    localparam int          DIV5_SH      = 18;
    localparam logic [15:0] DIV5_RECIP   = 16'd52429;

    // configuration registers
    logic [11:0] r_throttle_low;
    logic [11:0] r_throttle_high;
    logic [11:0] r_full_speed_div;
    logic [14:0] r_band_full;
    logic [14:0] r_band_stopped;
    logic [14:0] r_band_standstill;
    logic [14:0] r_rolling_min;
    logic [14:0] r_slew_step;

    // sequencer and state
    t_state r_state;
    t_state n_state;
    logic [COUNT_W-1:0]       r_last_count;
    logic                     r_primed;
    logic signed [CMD_W-1:0]  r_held;

    // working registers
    logic [SAMPLE_W-1:0]      r_sample;
    logic [COUNT_W-1:0]       r_count;
    logic signed [DELTA_W-1:0] r_delta;
    logic [QREG_W-1:0]        r_pedal;
    logic signed [15:0]       r_speed;
    logic [15:0]              r_band;
    logic signed [34:0]       r_prod;
    logic signed [CW-1:0]     r_cmd;
    logic [DIV_Q_W-1:0]       r_width;

    // output register
    logic                     r_out_valid;
    logic [PULSE_W-1:0]       r_pulse_compare;
    logic signed [DELTA_W-1:0] r_count_delta;
    logic signed [CMD_W-1:0]  r_drive_command;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    //------------------------------------------------------------------
    // Configuration writes
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle_low    <= THROTTLE_LOW_RST;
            r_throttle_high   <= THROTTLE_HIGH_RST;
            r_full_speed_div  <= FULL_SPEED_DIV_RST;
            r_band_full       <= BAND_FULL_RST;
            r_band_stopped    <= BAND_STOPPED_RST;
            r_band_standstill <= BAND_STANDSTILL_RST;
            r_rolling_min     <= ROLLING_MIN_RST;
            r_slew_step       <= SLEW_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_THROTTLE_LOW:       r_throttle_low    <= i_cfg_data[11:0];
                CFG_THROTTLE_HIGH:      r_throttle_high   <= i_cfg_data[11:0];
                CFG_FULL_SPEED_DIVISOR: r_full_speed_div  <= i_cfg_data[11:0];
                CFG_BAND_FULL:          r_band_full       <= i_cfg_data;
                CFG_BAND_STOPPED:       r_band_stopped    <= i_cfg_data;
                CFG_BAND_STANDSTILL:    r_band_standstill <= i_cfg_data;
                CFG_ROLLING_MIN:        r_rolling_min     <= i_cfg_data;
                CFG_SLEW_STEP:          r_slew_step       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Count delta with wrap correction; both +half and -half can appear
    //------------------------------------------------------------------
    logic signed [13:0] w_raw_delta;
    logic signed [13:0] w_wrap_delta;

    assign w_raw_delta = $signed({2'b00, r_count}) - $signed({2'b00, r_last_count});
    assign w_wrap_delta = (w_raw_delta < -HALF_MOD) ? w_raw_delta + FULL_MOD :
                          (w_raw_delta > HALF_MOD)  ? w_raw_delta - FULL_MOD :
                                                      w_raw_delta;

    //------------------------------------------------------------------
    // Pedal: divide only when the sample lies strictly between the limits;
    // otherwise the result is zero or full pedal outright.
    //------------------------------------------------------------------
    logic                 w_hi_gt_lo;
    logic [11:0]          w_span;
    logic [11:0]          w_pedal_off;
    logic                 w_pedal_div;
    logic [QREG_W-1:0]    w_pedal_fixed;
    logic [DIV_NUM_W-1:0] w_pedal_num;

    assign w_hi_gt_lo  = (r_throttle_high > r_throttle_low);
    assign w_span      = r_throttle_high - r_throttle_low;
    assign w_pedal_off = r_sample - r_throttle_low;
    assign w_pedal_div = w_hi_gt_lo && (r_sample > r_throttle_low)
                         && (r_sample < r_throttle_high);
    assign w_pedal_fixed = w_hi_gt_lo ?
                           ((r_sample >= r_throttle_high) ? QREG_W'(Q_ONE) : '0) :
                           ((r_sample >  r_throttle_low)  ? QREG_W'(Q_ONE) : '0);
    assign w_pedal_num = DIV_NUM_W'({w_pedal_off, {Q_FRAC{1'b0}}})
                         + DIV_NUM_W'(w_span >> 1);

    //------------------------------------------------------------------
    // Speed: sign-magnitude division, round half up for negative deltas via ceil
    //------------------------------------------------------------------
    logic [11:0]          w_div_d;
    logic                 w_delta_neg;
    logic signed [DELTA_W-1:0] w_delta_abs;
    logic [11:0]          w_delta_mag;
    logic                 w_speed_sat;
    logic [DIV_NUM_W-1:0] w_mag_shift;
    logic [DIV_NUM_W-1:0] w_speed_num;
    logic signed [15:0]   w_speed_sat_val;
    logic signed [15:0]   w_speed_q;

    assign w_div_d     = (r_full_speed_div == '0) ? 12'd1 : r_full_speed_div;
    assign w_delta_neg = r_delta[DELTA_W-1];
    assign w_delta_abs = w_delta_neg ? -r_delta : r_delta;
    assign w_delta_mag = w_delta_abs[11:0];
    assign w_speed_sat = (w_delta_mag >= w_div_d);
    assign w_mag_shift = DIV_NUM_W'({w_delta_mag, {Q_FRAC{1'b0}}});
    assign w_speed_num = w_delta_neg ?
                         w_mag_shift - DIV_NUM_W'(w_div_d >> 1) + DIV_NUM_W'(w_div_d)
                         - DIV_NUM_W'(1) :
                         w_mag_shift + DIV_NUM_W'(w_div_d >> 1);
    assign w_speed_sat_val = w_delta_neg ? -16'sd16384 : 16'sd16384;
    assign w_speed_q = w_delta_neg ? -$signed({1'b0, w_div_rsp.quot})
                                   :  $signed({1'b0, w_div_rsp.quot});

    //------------------------------------------------------------------
    // Shared multiplier: band slope product, then pulse width product
    //------------------------------------------------------------------
    logic [QREG_W-1:0]  w_abs_speed;
    logic signed [15:0] w_speed_abs16;
    logic signed [17:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [34:0] w_mul_p;

    assign w_speed_abs16 = (r_speed < 0) ? -r_speed : r_speed;
    assign w_abs_speed   = w_speed_abs16[QREG_W-1:0];

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_BAND_MUL: begin
                w_mul_a = $signed({3'b000, w_abs_speed});
                w_mul_b = $signed({2'b00, r_band_full}) - $signed({2'b00, r_band_stopped});
            end
            S_PULSE_MUL: begin
                w_mul_a = $signed(18'(PULSE_OFFSET)) - $signed({{2{r_held[CMD_W-1]}}, r_held});
                w_mul_b = $signed({1'b0, PERIOD_V});
            end
            default: ;
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    //------------------------------------------------------------------
    // Band half-width
    //------------------------------------------------------------------
    logic signed [34:0] w_band_round;
    logic signed [34:0] w_band_shift;
    logic signed [21:0] w_band_sum;
    logic [15:0]        w_band_next;

    assign w_band_round = r_prod + 35'sd8192;
    assign w_band_shift = w_band_round >>> Q_FRAC;
    assign w_band_sum   = $signed({w_band_shift[20], w_band_shift[20:0]})
                          + $signed({7'b0, r_band_stopped});
    assign w_band_next  = (w_abs_speed < QREG_W'(STANDSTILL_SPEED)) ?
                          {1'b0, r_band_standstill} : w_band_sum[15:0];

    //------------------------------------------------------------------
    // Band clamp around speed, wider on the side away from travel
    //------------------------------------------------------------------
    logic signed [CW-1:0] w_s;
    logic signed [CW-1:0] w_b;
    logic signed [CW-1:0] w_b2;
    logic signed [CW-1:0] w_p;
    logic signed [CW-1:0] w_band_lo;
    logic signed [CW-1:0] w_band_hi;
    logic signed [CW-1:0] w_clamp1;
    logic signed [CW-1:0] w_clamp;

    assign w_s  = CW'(r_speed);
    assign w_b  = $signed({3'b000, r_band});
    assign w_b2 = $signed({2'b00, r_band, 1'b0});
    assign w_p  = $signed({4'b0000, r_pedal});
    assign w_band_lo = (r_speed > 0) ? w_s - w_b2 : w_s - w_b;
    assign w_band_hi = (r_speed > 0) ? w_s + w_b  : w_s + w_b2;
    assign w_clamp1  = (w_p < w_band_lo) ? w_band_lo : w_p;
    assign w_clamp   = (w_clamp1 > w_band_hi) ? w_band_hi : w_clamp1;

    //------------------------------------------------------------------
    // Rolling floor, then slew limit and saturation to the command width
    //------------------------------------------------------------------
    logic signed [CW-1:0]    w_rmin;
    logic signed [CW-1:0]    w_floor;
    logic signed [CW-1:0]    w_held;
    logic signed [CW-1:0]    w_step;
    logic signed [CW-1:0]    w_slew_lo;
    logic signed [CW-1:0]    w_slew_hi;
    logic signed [CW-1:0]    w_slew;
    logic signed [CW-1:0]    w_slew_sat;

    assign w_rmin  = $signed({4'b0000, r_rolling_min});
    assign w_floor = ((r_speed > $signed(16'(ROLLING_SPEED))) && (r_cmd < w_rmin)) ?
                     w_rmin : r_cmd;
    assign w_held    = CW'(r_held);
    assign w_step    = $signed({4'b0000, r_slew_step});
    assign w_slew_lo = w_held - w_step;
    assign w_slew_hi = w_held + w_step;
    assign w_slew    = (r_cmd < w_slew_lo) ? w_slew_lo :
                       (r_cmd > w_slew_hi) ? w_slew_hi : r_cmd;
    assign w_slew_sat = (w_slew < CMD_LO) ? CMD_LO :
                        (w_slew > CMD_HI) ? CMD_HI : w_slew;

    //------------------------------------------------------------------
    // Pulse compare: drop the power-of-two part of the denominator with a
    // shift, then divide by 5 with a reciprocal multiply
    //------------------------------------------------------------------
    logic [DIV_NUM_W-1:0]              w_pulse_num;
    logic [DIV_NUM_W-PULSE_DEN_SH-1:0] w_pulse_y;
    logic [DIV_NUM_W-1:0]              w_pulse_yq;
    logic [DIV_Q_W-1:0]                w_pulse_q;
    logic signed [PULSE_W:0] w_width_m1;
    logic [PULSE_W-1:0]     w_compare;

    assign w_pulse_num = r_prod[DIV_NUM_W-1:0] + DIV_NUM_W'(PULSE_DEN / 2);
    assign w_pulse_y   = w_pulse_num[DIV_NUM_W-1:PULSE_DEN_SH];
    assign w_pulse_yq  = w_pulse_y * DIV5_RECIP;
    assign w_pulse_q   = w_pulse_yq[DIV5_SH +: DIV_Q_W];
    assign w_width_m1  = $signed({{(PULSE_W + 1 - DIV_Q_W){1'b0}}, r_width})
                         - (PULSE_W + 1)'(1);
    assign w_compare   = (w_width_m1 < 0)          ? '0 :
                         (w_width_m1 > PERIOD_MAX) ? PERIOD_MAX[PULSE_W-1:0] :
                                                     w_width_m1[PULSE_W-1:0];

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    logic w_out_load;

    assign w_out_load = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        w_div_req = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DELTA;
            end
            S_DELTA: begin
                if (w_pedal_div) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = w_pedal_num;
                    w_div_req.den   = DIV_DEN_W'(w_span);
                    n_state = S_PEDAL_WAIT;
                end else begin
                    n_state = S_SPEED;
                end
            end
            S_PEDAL_WAIT: begin
                if (w_div_rsp.done) n_state = S_SPEED;
            end
            S_SPEED: begin
                if (!w_speed_sat) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = w_speed_num;
                    w_div_req.den   = DIV_DEN_W'(w_div_d);
                    n_state = S_SPEED_WAIT;
                end else begin
                    n_state = S_BAND_MUL;
                end
            end
            S_SPEED_WAIT: begin
                if (w_div_rsp.done) n_state = S_BAND_MUL;
            end
            S_BAND_MUL:  n_state = S_BAND;
            S_BAND:      n_state = S_CLAMP;
            S_CLAMP:     n_state = S_FLOOR;
            S_FLOOR:     n_state = S_SLEW;
            S_SLEW:      n_state = S_PULSE_MUL;
            S_PULSE_MUL: n_state = S_PULSE_DIV;
            S_PULSE_DIV: n_state = S_DONE;
            S_DONE: begin
                // hold here until the output register frees up
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_count <= '0;
            r_primed     <= 1'b0;
            r_held       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DELTA) begin
                r_last_count <= r_count;
                r_primed     <= 1'b1;
            end
            if (r_state == S_SLEW) begin
                r_held <= w_slew_sat[CMD_W-1:0];
            end
            if ((r_state == S_DONE) && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_sample <= i_throttle_sample;
                    r_count  <= i_encoder_count;
                end
            end
            S_DELTA: begin
                // first word after reset reports no motion
                r_delta <= r_primed ? w_wrap_delta[DELTA_W-1:0] : '0;
                r_pedal <= w_pedal_fixed;
            end
            S_PEDAL_WAIT: begin
                if (w_div_rsp.done) r_pedal <= w_div_rsp.quot;
            end
            S_SPEED: begin
                if (w_speed_sat) r_speed <= w_speed_sat_val;
            end
            S_SPEED_WAIT: begin
                if (w_div_rsp.done) r_speed <= w_speed_q;
            end
            S_BAND_MUL:  r_prod  <= w_mul_p;
            S_BAND:      r_band  <= w_band_next;
            S_CLAMP:     r_cmd   <= w_clamp;
            S_FLOOR:     r_cmd   <= w_floor;
            S_PULSE_MUL: r_prod  <= w_mul_p;
            S_PULSE_DIV: r_width <= w_pulse_q;
            S_DONE: begin
                if (w_out_load) begin
                    r_pulse_compare <= w_compare;
                    r_count_delta   <= r_delta;
                    r_drive_command <= r_held;
                end
            end
            default: ;
        endcase
    end

    tcbsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_pulse_compare = r_pulse_compare;
    assign o_count_delta   = r_count_delta;
    assign o_drive_command = r_drive_command;

    logic w_div_wait;
    logic w_band_step;
    logic w_speed_in_range;

    assign w_div_wait       = (r_state == S_PEDAL_WAIT) || (r_state == S_SPEED_WAIT);
    assign w_band_step      = (r_state == S_BAND_MUL);
    assign w_speed_in_range = (r_speed >= -16'sd16384) && (r_speed <= 16'sd16384);

    `ASSERT_IMPLY(a_div_done_in_wait, i_clk, i_rst_n, w_div_rsp.done, w_div_wait)
    `ASSERT_IMPLY(a_speed_range, i_clk, i_rst_n, w_band_step, w_speed_in_range)
    `ASSERT_IMPLY(a_pedal_range, i_clk, i_rst_n, w_band_step, r_pedal <= QREG_W'(Q_ONE))

endmodule

`default_nettype wire
